FILE: hw/rtl/tdd_pkg.sv
`timescale 1ns / 1ps

package tdd_pkg;

   localparam int TILT_F_W = 13;
   localparam int TILT_S_W = 12;
   localparam int DIST_W = 16;
   localparam int CFG_W = 11;
   localparam int ACT_W = 3;
   localparam int DUTY_W = 7;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int NUM_W = 26;
   localparam int QUO_W = 15;
   localparam int PROD_W = 30;
   localparam int SCL_SHIFT = 8;
   localparam int RECIP_W = 26;
   localparam int RECIP_SHIFT = 32;
   localparam int DUTY_SHIFT = 9;

   localparam logic [QUO_W-1:0] FULL_Q = 15'd25600;
   localparam logic [QUO_W-1:0] ONE_PCT_Q = 15'd256;
   localparam logic [NUM_W-1:0] FULL_Q_NUM = 26'd25600;
   localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;
   localparam logic [DIST_W-1:0] MIN_DIST = 16'd16;
   localparam logic [DUTY_W-1:0] DUTY_BASE = 7'd50;

   localparam logic [CFG_W-1:0] DEAD_ZONE_RESET = 11'd192;
   localparam logic [CFG_W-1:0] FULL_TILT_RESET = 11'd720;
   localparam logic [DIST_W-1:0] STOP_DIST_RESET = 16'd320;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_ZONE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_TILT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_DISTANCE = 2'd2;

   typedef enum logic [ACT_W-1:0] {
      ACT_STOP       = 3'd0,
      ACT_OBSTACLE   = 3'd1,
      ACT_FORWARD    = 3'd2,
      ACT_BACKWARD   = 3'd3,
      ACT_SPIN_LEFT  = 3'd4,
      ACT_SPIN_RIGHT = 3'd5
   } action_type;

   typedef struct packed {
      logic valid;
      logic dead_f;
      logic dead_s;
      logic sat_f;
      logic sat_s;
      logic f_pos;
      logic s_pos;
      logic near;
   } side_type;

   function automatic logic [DUTY_W-1:0] duty_of(input logic [QUO_W-1:0] q);
      return DUTY_BASE + DUTY_W'(q >> DUTY_SHIFT);
   endfunction

endpackage

FILE: hw/rtl/tdd_prep.sv
`timescale 1ns / 1ps

module tdd_prep import tdd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en_i,
   input  logic                valid_i,
   input  logic [TILT_F_W-1:0] tilt_forward_i,
   input  logic [TILT_S_W-1:0] tilt_side_i,
   input  logic [DIST_W-1:0]   front_distance_i,
   input  logic [CFG_W-1:0]    dead_zone_i,
   input  logic [CFG_W-1:0]    span_i,
   input  logic                degen_i,
   input  logic [DIST_W-1:0]   stop_distance_i,
   output side_type            side_o,
   output logic [NUM_W-1:0]    num_f_o,
   output logic [NUM_W-1:0]    num_s_o
);

   logic [TILT_F_W-1:0] mag_f;
   logic [TILT_S_W-1:0] mag_s;
   logic [TILT_F_W-1:0] over_f;
   logic [TILT_S_W-1:0] over_s;
   side_type            side_in;
   side_type            side_ff;
   logic [NUM_W-1:0]    num_f_in;
   logic [NUM_W-1:0]    num_s_in;
   logic [NUM_W-1:0]    num_f_ff;
   logic [NUM_W-1:0]    num_s_ff;

   always_comb begin
      mag_f = tilt_forward_i[TILT_F_W-1] ? (~tilt_forward_i + 1'b1) : tilt_forward_i;
      mag_s = tilt_side_i[TILT_S_W-1] ? (~tilt_side_i + 1'b1) : tilt_side_i;
      over_f = mag_f - TILT_F_W'(dead_zone_i);
      over_s = mag_s - TILT_S_W'(dead_zone_i);

      side_in.valid = valid_i;
      side_in.dead_f = mag_f <= TILT_F_W'(dead_zone_i);
      side_in.dead_s = mag_s <= TILT_S_W'(dead_zone_i);
      side_in.sat_f = degen_i || (over_f >= TILT_F_W'(span_i));
      side_in.sat_s = degen_i || (over_s >= TILT_S_W'(span_i));
      side_in.f_pos = !tilt_forward_i[TILT_F_W-1] && (tilt_forward_i != '0);
      side_in.s_pos = !tilt_side_i[TILT_S_W-1] && (tilt_side_i != '0);
      side_in.near = (front_distance_i > MIN_DIST) && (front_distance_i < stop_distance_i);

      num_f_in = NUM_W'(over_f[CFG_W-1:0]) * FULL_Q_NUM;
      num_s_in = NUM_W'(over_s[CFG_W-1:0]) * FULL_Q_NUM;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else if (en_i) begin
         side_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_i) begin
         num_f_ff <= num_f_in;
         num_s_ff <= num_s_in;
      end
   end

   assign side_o = side_ff;
   assign num_f_o = num_f_ff;
   assign num_s_o = num_s_ff;

endmodule

FILE: hw/rtl/tdd_div.sv
`timescale 1ns / 1ps

module tdd_div import tdd_pkg::*; #(
   parameter int NUM_W_P = NUM_W,
   parameter int DEN_W_P = CFG_W,
   parameter int QUO_W_P = QUO_W
) (
   input  logic               clock,
   input  logic               en_i,
   input  logic [NUM_W_P-1:0] num_i,
   input  logic [DEN_W_P-1:0] den_i,
   output logic [QUO_W_P-1:0] quo_o
);

   logic [DEN_W_P-1:0] rem_ff [QUO_W_P-1];
   logic [NUM_W_P-1:0] num_ff [QUO_W_P-1];
   logic [QUO_W_P-1:0] quo_ff [QUO_W_P];

   for (genvar s = 0; s < QUO_W_P; s++) begin : g_stage
      logic [DEN_W_P-1:0] rem_prev;
      logic [NUM_W_P-1:0] num_prev;
      logic [QUO_W_P-1:0] quo_prev;
      logic [DEN_W_P:0]   trial;
      logic               ge;
      logic [DEN_W_P-1:0] rem_in;
      logic [QUO_W_P-1:0] quo_in;

      if (s == 0) begin : g_first
         assign rem_prev = DEN_W_P'(num_i >> QUO_W_P);
         assign num_prev = num_i;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign num_prev = num_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end

      assign trial = {rem_prev, num_prev[QUO_W_P-1-s]};
      assign ge = trial >= {1'b0, den_i};
      assign rem_in = ge ? DEN_W_P'(trial - {1'b0, den_i}) : trial[DEN_W_P-1:0];
      assign quo_in = {quo_prev[QUO_W_P-2:0], ge};

      always_ff @(posedge clock) begin
         if (en_i) begin
            quo_ff[s] <= quo_in;
         end
      end

      if (s < QUO_W_P - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en_i) begin
               rem_ff[s] <= rem_in;
               num_ff[s] <= num_prev;
            end
         end
      end
   end

   assign quo_o = quo_ff[QUO_W_P-1];

endmodule

FILE: hw/rtl/tdd_mix.sv
`timescale 1ns / 1ps

module tdd_mix import tdd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en_i,
   input  side_type          side_i,
   input  logic [QUO_W-1:0]  qf_i,
   input  logic [QUO_W-1:0]  qs_i,
   output logic              valid_o,
   output logic [ACT_W-1:0]  action_o,
   output logic [DUTY_W-1:0] left_o,
   output logic [DUTY_W-1:0] right_o
);

   localparam int SCL_W = PROD_W - SCL_SHIFT;
   localparam int RMUL_W = SCL_W + RECIP_W;

   side_type              m1_side_ff;
   side_type              m2_side_ff;
   logic [QUO_W-1:0]      speed_in;
   logic [QUO_W-1:0]      turn_in;
   logic [PROD_W-1:0]     prod_in;
   logic [QUO_W-1:0]      speed1_ff;
   logic [QUO_W-1:0]      turn1_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [RMUL_W-1:0]     rmul;
   logic [QUO_W-1:0]      slow_in;
   logic [QUO_W-1:0]      speed2_ff;
   logic [QUO_W-1:0]      turn2_ff;
   logic [QUO_W-1:0]      slow_ff;
   logic [QUO_W-1:0]      lq;
   logic [QUO_W-1:0]      rq;
   action_type            action_in;
   logic [DUTY_W-1:0]     left_in;
   logic [DUTY_W-1:0]     right_in;
   logic                  valid_ff;
   action_type            action_ff;
   logic [DUTY_W-1:0]     left_ff;
   logic [DUTY_W-1:0]     right_ff;

   always_comb begin
      speed_in = side_i.dead_f ? '0 : (side_i.sat_f ? FULL_Q : qf_i);
      turn_in = side_i.dead_s ? '0 : (side_i.sat_s ? FULL_Q : qs_i);
      prod_in = PROD_W'(speed_in) * PROD_W'(FULL_Q - turn_in);
   end

   assign rmul = RMUL_W'(prod_ff[PROD_W-1:SCL_SHIFT]) * RMUL_W'(RECIP_100);
   assign slow_in = rmul[RECIP_SHIFT +: QUO_W];

   always_comb begin
      lq = speed2_ff;
      rq = speed2_ff;
      if (!m2_side_ff.dead_s) begin
         if (m2_side_ff.s_pos) begin
            rq = slow_ff;
         end else begin
            lq = slow_ff;
         end
      end

      action_in = ACT_STOP;
      left_in = '0;
      right_in = '0;
      if (!(m2_side_ff.dead_f && m2_side_ff.dead_s)) begin
         if (m2_side_ff.dead_f) begin
            action_in = m2_side_ff.s_pos ? ACT_SPIN_RIGHT : ACT_SPIN_LEFT;
            left_in = duty_of(turn2_ff);
            right_in = duty_of(turn2_ff);
         end else if (m2_side_ff.f_pos && m2_side_ff.near) begin
            action_in = ACT_OBSTACLE;
         end else begin
            action_in = m2_side_ff.f_pos ? ACT_FORWARD : ACT_BACKWARD;
            if (lq > ONE_PCT_Q) begin
               left_in = duty_of(lq);
            end
            if (rq > ONE_PCT_Q) begin
               right_in = duty_of(rq);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_side_ff <= '0;
         m2_side_ff <= '0;
         valid_ff <= 1'b0;
      end else if (en_i) begin
         m1_side_ff <= side_i;
         m2_side_ff <= m1_side_ff;
         valid_ff <= m2_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_i) begin
         speed1_ff <= speed_in;
         turn1_ff <= turn_in;
         prod_ff <= prod_in;
         speed2_ff <= speed1_ff;
         turn2_ff <= turn1_ff;
         slow_ff <= slow_in;
         action_ff <= action_in;
         left_ff <= left_in;
         right_ff <= right_in;
      end
   end

   assign valid_o = valid_ff;
   assign action_o = action_ff;
   assign left_o = left_ff;
   assign right_o = right_ff;

endmodule

FILE: hw/rtl/tilt_to_differential_drive_unit.sv
`timescale 1ns / 1ps

// Turns one tilt sample (forward tilt, side tilt, front distance) into one motor
// command with a drive action and left and right duty in percent. The block
// takes one item in every cycle while the result side does not stall. Each
// item passes through the magnitude and dead-zone compare register, the two
// pipelined radix-2 dividers that scale the tilts, the turn-side multiply and
// the divide by 25600, and the output register. A stall on the result side
// holds the whole pipeline, so nothing is lost or repeated. The user must write
// registers through the csr_ port only while no item is in flight; the block
// itself does not enforce this.

module tilt_to_differential_drive_unit import tdd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tilt_forward[12:0], tilt_side[24:13], front_distance[40:25], zero fill
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // drive_action[2:0], left_duty[9:3], right_duty[16:10], zero fill
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [CFG_W-1:0]  dead_zone_ff;
   logic [CFG_W-1:0]  full_tilt_ff;
   logic [DIST_W-1:0] stop_distance_ff;
   logic [CFG_W-1:0]  span;
   logic              degen;
   logic              en;
   side_type          prep_side;
   logic [NUM_W-1:0]  num_f;
   logic [NUM_W-1:0]  num_s;
   side_type          div_side_ff [QUO_W];
   logic [QUO_W-1:0]  qf;
   logic [QUO_W-1:0]  qs;
   logic [ACT_W-1:0]  action;
   logic [DUTY_W-1:0] left_duty;
   logic [DUTY_W-1:0] right_duty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DEAD_ZONE_RESET;
         full_tilt_ff <= FULL_TILT_RESET;
         stop_distance_ff <= STOP_DIST_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DEAD_ZONE: begin
               dead_zone_ff <= csr_data[CFG_W-1:0];
            end
            CSR_FULL_TILT: begin
               full_tilt_ff <= csr_data[CFG_W-1:0];
            end
            CSR_STOP_DISTANCE: begin
               stop_distance_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign span = full_tilt_ff - dead_zone_ff;
   assign degen = full_tilt_ff <= dead_zone_ff;

   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   tdd_prep u_prep (
      .clock            (clock),
      .reset            (reset),
      .en_i             (en),
      .valid_i          (req_tvalid),
      .tilt_forward_i   (req_tdata[12:0]),
      .tilt_side_i      (req_tdata[24:13]),
      .front_distance_i (req_tdata[40:25]),
      .dead_zone_i      (dead_zone_ff),
      .span_i           (span),
      .degen_i          (degen),
      .stop_distance_i  (stop_distance_ff),
      .side_o           (prep_side),
      .num_f_o          (num_f),
      .num_s_o          (num_s)
   );

   tdd_div #(
      .NUM_W_P (NUM_W),
      .DEN_W_P (CFG_W),
      .QUO_W_P (QUO_W)
   ) u_div_f (
      .clock (clock),
      .en_i  (en),
      .num_i (num_f),
      .den_i (span),
      .quo_o (qf)
   );

   tdd_div #(
      .NUM_W_P (NUM_W),
      .DEN_W_P (CFG_W),
      .QUO_W_P (QUO_W)
   ) u_div_s (
      .clock (clock),
      .en_i  (en),
      .num_i (num_s),
      .den_i (span),
      .quo_o (qs)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUO_W; i++) begin
            div_side_ff[i] <= '0;
         end
      end else if (en) begin
         div_side_ff[0] <= prep_side;
         for (int i = 1; i < QUO_W; i++) begin
            div_side_ff[i] <= div_side_ff[i-1];
         end
      end
   end

   tdd_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .en_i     (en),
      .side_i   (div_side_ff[QUO_W-1]),
      .qf_i     (qf),
      .qs_i     (qs),
      .valid_o  (rsp_tvalid),
      .action_o (action),
      .left_o   (left_duty),
      .right_o  (right_duty)
   );

   assign rsp_tdata = {7'd0, right_duty, left_duty, action};

   a_stop_zero_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == ACT_STOP || rsp_tdata[2:0] == ACT_OBSTACLE)
      |-> rsp_tdata[9:3] == 7'd0 && rsp_tdata[16:10] == 7'd0)
      else $error("stop command with nonzero duty");

   a_spin_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == ACT_SPIN_LEFT || rsp_tdata[2:0] == ACT_SPIN_RIGHT)
      |-> rsp_tdata[9:3] == rsp_tdata[16:10] && rsp_tdata[9:3] >= DUTY_BASE)
      else $error("spin command with unequal or low duty");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[9:3] <= 7'd100 && rsp_tdata[16:10] <= 7'd100)
      else $error("duty above full scale");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tdd_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int RESET_CYCLES = 8;
   localparam int SETTLE_CYCLES = 25;
   localparam int TAIL_CYCLES = 40;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 2000;
   localparam int PRINT_CAP = 40;
   localparam int FULL_SCALE = 25600;
   localparam int ONE_PERCENT = 256;
   localparam int MIN_DISTANCE = 16;
   localparam int DUTY_FLOOR = 50;
   localparam int MAX_TILT_F = 2880;
   localparam int MAX_TILT_S = 1440;
   localparam int MAX_DIST = 65535;
   localparam int NUM_PHASES = 9;
   localparam int FIRST_RANDOM = 80;
   localparam int PHASE_ITEMS = 56;
   localparam int HOLD_PHASE = 3;

   typedef struct packed {
      action_type        action;
      logic [DUTY_W-1:0] left_duty;
      logic [DUTY_W-1:0] right_duty;
   } motor_cmd_type;

   class drive_scoreboard;
      int unsigned   dead_zone;
      int unsigned   full_tilt;
      int unsigned   stop_distance;
      motor_cmd_type expected_cmds[$];
      int            errors;

      function new();
         dead_zone = DEAD_ZONE_RESET;
         full_tilt = FULL_TILT_RESET;
         stop_distance = STOP_DIST_RESET;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_DEAD_ZONE: dead_zone = value[CFG_W-1:0];
            CSR_FULL_TILT: full_tilt = value[CFG_W-1:0];
            CSR_STOP_DISTANCE: stop_distance = value;
            default: ;
         endcase
      endfunction

      function int unsigned scale_tilt(int unsigned mag);
         int unsigned over;
         int unsigned span;
         int unsigned q;
         if (mag <= dead_zone) return 0;
         if (full_tilt <= dead_zone) return FULL_SCALE;
         over = mag - dead_zone;
         span = full_tilt - dead_zone;
         if (over >= span) return FULL_SCALE;
         q = (over * FULL_SCALE) / span;
         return (q > FULL_SCALE) ? FULL_SCALE : q;
      endfunction

      function logic [DUTY_W-1:0] duty_for(int unsigned q);
         return DUTY_W'(DUTY_FLOOR + (q >> 9));
      endfunction

      function motor_cmd_type mix_tilts(logic [REQ_DATA_W-1:0] data);
         logic signed [TILT_F_W-1:0] tilt_f;
         logic signed [TILT_S_W-1:0] tilt_s;
         int unsigned distance;
         int unsigned mag_f;
         int unsigned mag_s;
         int unsigned speed;
         int unsigned turn;
         int unsigned slowed;
         int unsigned left_q;
         int unsigned right_q;
         motor_cmd_type cmd;
         tilt_f = data[TILT_F_W-1:0];
         tilt_s = data[TILT_F_W +: TILT_S_W];
         distance = data[TILT_F_W+TILT_S_W +: DIST_W];
         mag_f = (tilt_f < 0) ? -int'(tilt_f) : int'(tilt_f);
         mag_s = (tilt_s < 0) ? -int'(tilt_s) : int'(tilt_s);
         cmd.action = ACT_STOP;
         cmd.left_duty = '0;
         cmd.right_duty = '0;
         if (mag_f <= dead_zone && mag_s <= dead_zone) begin
            cmd.action = ACT_STOP;
         end else if (mag_f <= dead_zone) begin
            cmd.action = (tilt_s > 0) ? ACT_SPIN_RIGHT : ACT_SPIN_LEFT;
            cmd.left_duty = duty_for(scale_tilt(mag_s));
            cmd.right_duty = cmd.left_duty;
         end else begin
            speed = scale_tilt(mag_f);
            left_q = speed;
            right_q = speed;
            if (mag_s > dead_zone) begin
               turn = scale_tilt(mag_s);
               slowed = (speed * (FULL_SCALE - turn)) / FULL_SCALE;
               if (tilt_s > 0) right_q = slowed;
               else left_q = slowed;
            end
            if (left_q > ONE_PERCENT) cmd.left_duty = duty_for(left_q);
            if (right_q > ONE_PERCENT) cmd.right_duty = duty_for(right_q);
            if (tilt_f > 0) begin
               if (distance > MIN_DISTANCE && distance < stop_distance) begin
                  cmd.action = ACT_OBSTACLE;
                  cmd.left_duty = '0;
                  cmd.right_duty = '0;
               end else begin
                  cmd.action = ACT_FORWARD;
               end
            end else begin
               cmd.action = ACT_BACKWARD;
            end
         end
         return cmd;
      endfunction

      function void note_request(logic [REQ_DATA_W-1:0] data);
         expected_cmds.push_back(mix_tilts(data));
      endfunction

      function int pending();
         return expected_cmds.size();
      endfunction

      task report(string msg);
         if (errors < PRINT_CAP) $display("%0t ns: %s", $time, msg);
         errors++;
      endtask

      task check_response(logic [RSP_DATA_W-1:0] data);
         motor_cmd_type want;
         logic [ACT_W-1:0] got_action;
         logic [DUTY_W-1:0] got_left;
         logic [DUTY_W-1:0] got_right;
         got_action = data[ACT_W-1:0];
         got_left = data[ACT_W +: DUTY_W];
         got_right = data[ACT_W+DUTY_W +: DUTY_W];
         if (expected_cmds.size() == 0) begin
            report($sformatf("unexpected command, data 0x%h", data));
         end else begin
            want = expected_cmds.pop_front();
            if (got_action !== want.action)
               report($sformatf("drive_action got %0d, expected %0d", got_action, want.action));
            if (got_left !== want.left_duty)
               report($sformatf("left_duty got %0d, expected %0d", got_left, want.left_duty));
            if (got_right !== want.right_duty)
               report($sformatf("right_duty got %0d, expected %0d", got_right, want.right_duty));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   drive_scoreboard sb;
   bit no_gaps;
   bit rx_hold_request;
   int rx_stall;
   int quiet_cycles;

   tilt_to_differential_drive_unit uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   always @(negedge clock) begin
      if (rx_hold_request) begin
         rx_stall = RX_HOLD_CYCLES;
         rx_hold_request = 1'b0;
      end else if (rx_stall == 0) begin
         rx_stall = pick_gap();
      end
      if (rx_stall > 0) begin
         rsp_tready <= 1'b0;
         rx_stall--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   task send_tilt(int tilt_f, int tilt_s, int distance);
      int gap;
      req_tdata <= REQ_DATA_W'({distance[DIST_W-1:0], tilt_s[TILT_S_W-1:0],
                                tilt_f[TILT_F_W-1:0]});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task write_csr(logic [CSR_INDEX_W-1:0] index, int value);
      csr_index <= index;
      csr_data <= value[CSR_DATA_W-1:0];
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function int rand_tilt(int limit, int dz, int ft);
      int v;
      case ($urandom_range(9))
         0: v = 0;
         1: v = limit;
         2: v = dz + int'($urandom_range(2)) - 1;
         3: v = ft + int'($urandom_range(2)) - 1;
         default: v = $urandom_range(limit);
      endcase
      if (v > limit) v = limit;
      if (v < 0) v = 0;
      return $urandom_range(1) ? -v : v;
   endfunction

   function int rand_dist(int sd);
      int v;
      case ($urandom_range(7))
         0: v = $urandom_range(20);
         1: v = (sd > 0) ? sd - 1 : 0;
         2: v = sd;
         3: v = MAX_DIST;
         4, 5: v = $urandom_range((2 * sd > MAX_DIST) ? MAX_DIST : 2 * sd);
         default: v = $urandom_range(MAX_DIST);
      endcase
      return v;
   endfunction

   initial begin
      int dir_f[] = '{0, 192, 193, -193, 2880, -2880, 720, 0, 0, 0, 0, 2880, 2880,
                      1000, -1000, 2880, 2880, 2880, 2880, -2880, -1, -2880};
      int dir_s[] = '{0, -192, 0, 0, 0, 0, 0, 1440, -1440, 193, -200, 1440, -1440,
                      400, -400, 0, 0, 0, 0, 1440, -1, -1440};
      int dir_d[] = '{0, 500, 500, 0, 500, 5, 1000, 0, 0, 0, 0, 1000, 1000,
                      1000, 1000, 16, 17, 319, 320, 100, 65535, 65535};
      int cfg_dz[] = '{192, 0, 1440, 1440, 700, 0, -1, -1, -1};
      int cfg_ft[] = '{720, 16, 1440, 16, 16, 1440, -1, -1, -1};
      int cfg_sd[] = '{320, 0, 65535, 65535, 1000, 17, -1, -1, -1};
      int dz;
      int ft;
      int sd;
      int count;

      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_DEAD_ZONE;
      csr_data = '0;
      no_gaps = 1'b0;
      rx_hold_request = 1'b0;
      rx_stall = 0;
      quiet_cycles = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_f[i]) send_tilt(dir_f[i], dir_s[i], dir_d[i]);

      for (int p = 0; p < NUM_PHASES; p++) begin
         dz = cfg_dz[p];
         ft = cfg_ft[p];
         sd = cfg_sd[p];
         if (dz < 0) begin
            dz = $urandom_range(400);
            ft = $urandom_range(MAX_TILT_S, 16);
            sd = $urandom_range(3) ? $urandom_range(2000) : $urandom_range(MAX_DIST);
         end
         if (p > 0) begin
            wait_drained();
            write_csr(CSR_DEAD_ZONE, dz);
            write_csr(CSR_FULL_TILT, ft);
            write_csr(CSR_STOP_DISTANCE, sd);
         end
         no_gaps = ($urandom_range(3) == 0);
         if (p == HOLD_PHASE) begin
            no_gaps = 1'b1;
            rx_hold_request = 1'b1;
         end
         count = (p == 0) ? FIRST_RANDOM : PHASE_ITEMS;
         for (int n = 0; n < count; n++) begin
            if ($urandom_range(39) == 0) wait_drained();
            send_tilt(rand_tilt(MAX_TILT_F, dz, ft), rand_tilt(MAX_TILT_S, dz, ft),
                      rand_dist(sd));
         end
      end

      no_gaps = 1'b0;
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
